>>> src/wos_pkg.sv
package wos_pkg;

	localparam int Depth = 256;
	localparam int SampleWidth = 32;
	localparam int AddrWidth = $clog2(Depth);
	localparam int CountWidth = $clog2(Depth + 1);
	localparam int WideWidth = SampleWidth + 1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_WRITE,
		S_MODE,
		S_PICK,
		S_FINAL,
		S_OUT
	} wos_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic search_start;
		logic search_step;
		logic shift_step;
		logic write_new;
		logic commit;
		logic mode_start;
		logic mode_step;
		logic pick_step;
		logic finish;
	} wos_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_remove;
		logic full;
		logic search_done;
		logic found;
		logic shift_done;
		logic mode_done;
		logic pick_done;
	} wos_stat_t;

endpackage

>>> src/wos_if.sv
interface wos_in_if;
	import wos_pkg::*;
	logic valid;
	logic ready;
	logic operation;
	logic signed [SampleWidth-1:0] sample;
	modport source (output valid, operation, sample, input ready);
	modport sink (input valid, operation, sample, output ready);
endinterface

interface wos_out_if;
	import wos_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [CountWidth-1:0] entry_total;
	logic stats_valid;
	logic signed [WideWidth-1:0] median_x2;
	logic signed [WideWidth-1:0] q1_x2;
	logic signed [WideWidth-1:0] q3_x2;
	logic [WideWidth-1:0] iqr_x2;
	logic signed [SampleWidth-1:0] mode_value;
	modport source (output valid, status, entry_total, stats_valid, median_x2, q1_x2,
		q3_x2, iqr_x2, mode_value, input ready);
	modport sink (input valid, status, entry_total, stats_valid, median_x2, q1_x2,
		q3_x2, iqr_x2, mode_value, output ready);
endinterface

>>> src/wos_ram.sv
module wos_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> src/wos_datapath.sv
module wos_datapath import wos_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wos_cmd_t                      cmd,
	output wos_stat_t                     stat,
	input  logic                          in_operation,
	input  logic signed [SampleWidth-1:0] in_sample,
	output logic [1:0]                    status,
	output logic [CountWidth-1:0]         entry_total,
	output logic                          stats_valid,
	output logic signed [WideWidth-1:0]   median_x2,
	output logic signed [WideWidth-1:0]   q1_x2,
	output logic signed [WideWidth-1:0]   q3_x2,
	output logic [WideWidth-1:0]          iqr_x2,
	output logic signed [SampleWidth-1:0] mode_value
);
	logic [CountWidth-1:0] count_q;
	logic op_q;
	logic signed [SampleWidth-1:0] sample_q;
	logic [CountWidth-1:0] ptr_q;       // entry pointer for the search, shift and mode scan walks
	logic [CountWidth-1:0] pos_q;
	logic rd_pend_q;
	logic search_done_q, found_q, shift_done_q, mode_done_q, pick_done_q;
	logic [1:0] status_q;

	logic we;
	logic [AddrWidth-1:0] waddr, raddr;
	logic [SampleWidth-1:0] wdata, rdata;
	logic signed [SampleWidth-1:0] rval;

	// Mode scan
	logic signed [SampleWidth-1:0] run_val_q, best_val_q;
	logic [CountWidth-1:0] run_len_q, best_len_q;

	// Median and quartile picks: six positions read in turn
	logic [2:0] pick_idx_q;
	logic [CountWidth-1:0] pick_addr [6];
	logic signed [SampleWidth-1:0] pick_val_q [6];
	logic [CountWidth-1:0] n_q, h_q;

	wos_ram #(.Width(SampleWidth), .Depth(Depth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rval = signed'(rdata);

	// Pick addresses for median (0,1), q1 (2,3), q3 (4,5)
	always_comb begin
		logic [CountWidth-1:0] m, mq, s3;
		m = n_q >> 1;
		mq = h_q >> 1;
		s3 = n_q - h_q;
		pick_addr[0] = n_q[0] ? m : m - 1'b1;
		pick_addr[1] = m;
		if (n_q == CountWidth'(1)) begin
			pick_addr[2] = '0;
			pick_addr[3] = '0;
			pick_addr[4] = '0;
			pick_addr[5] = '0;
		end else begin
			pick_addr[2] = h_q[0] ? mq : mq - 1'b1;
			pick_addr[3] = mq;
			pick_addr[4] = s3 + (h_q[0] ? mq : mq - 1'b1);
			pick_addr[5] = s3 + mq;
		end
	end

	// RAM address and write selection
	always_comb begin
		we = 1'b0;
		waddr = ptr_q[AddrWidth-1:0];
		wdata = rdata;
		raddr = ptr_q[AddrWidth-1:0];
		if (cmd.search_start || cmd.mode_start) begin
			raddr = '0;
		end else if (cmd.search_step || cmd.mode_step) begin
			raddr = AddrWidth'(ptr_q + 1'b1);
		end else if (cmd.pick_step) begin
			raddr = pick_addr[pick_idx_q][AddrWidth-1:0];
		end else if (cmd.shift_step) begin
			if (op_q == OP_INSERT) begin
				// read ptr-2, write ptr with data read last cycle
				raddr = AddrWidth'(ptr_q - 2'd2);
				we = rd_pend_q;
			end else begin
				raddr = AddrWidth'(ptr_q + 1'b1);
				we = rd_pend_q;
				waddr = AddrWidth'(ptr_q - 1'b1);
			end
		end
		if (cmd.write_new) begin
			we = 1'b1;
			waddr = pos_q[AddrWidth-1:0];
			wdata = sample_q;
		end
	end

	// Sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			pos_q <= '0;
			rd_pend_q <= 1'b0;
			search_done_q <= 1'b0;
			found_q <= 1'b0;
			shift_done_q <= 1'b0;
			mode_done_q <= 1'b0;
			pick_done_q <= 1'b0;
			pick_idx_q <= '0;
			op_q <= OP_INSERT;
			status_q <= ST_DONE;
		end else begin
			if (cmd.load) begin
				op_q <= in_operation;
				search_done_q <= 1'b0;
				found_q <= 1'b0;
				// flag an insert into a full store up front
				status_q <= (in_operation == OP_INSERT && count_q >= CountWidth'(Depth)) ?
					ST_FULL : ST_DONE;
			end
			// start linear search: read entry 0
			if (cmd.search_start) begin
				ptr_q <= '0;
				rd_pend_q <= (count_q != 0);
				search_done_q <= (count_q == 0);
				found_q <= 1'b0;
				pos_q <= '0;
				if (count_q == 0 && op_q == OP_REMOVE) status_q <= ST_MISSING;
			end
			// advance search, rdata holds entry ptr
			if (cmd.search_step && !search_done_q) begin
				if (op_q == OP_INSERT) begin
					if (rval > sample_q) begin
						search_done_q <= 1'b1;
						pos_q <= ptr_q;
					end
				end else if (rval == sample_q) begin
					search_done_q <= 1'b1;
					found_q <= 1'b1;
					pos_q <= ptr_q;
				end
				if (!(op_q == OP_INSERT ? rval > sample_q : rval == sample_q)) begin
					if (ptr_q + 1'b1 >= count_q) begin
						search_done_q <= 1'b1;
						pos_q <= count_q;
						if (op_q == OP_REMOVE) status_q <= ST_MISSING;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				if (op_q == OP_INSERT && !(rval > sample_q) && ptr_q + 1'b1 >= count_q) begin
					// ensure shift set up below
				end
			end
			// after search: prepare shift pointer
			if (cmd.search_step && search_done_q) begin
				rd_pend_q <= 1'b0;
				if (op_q == OP_INSERT) begin
					ptr_q <= count_q + 1'b1;
					shift_done_q <= (pos_q == count_q);
				end else begin
					ptr_q <= pos_q;
					shift_done_q <= (pos_q + 1'b1 >= count_q);
				end
			end
			// shift one entry per cycle: ptr is the write target on insert, (target + 1) on remove
			if (cmd.shift_step && !shift_done_q) begin
				rd_pend_q <= 1'b1;
				if (op_q == OP_INSERT) begin
					ptr_q <= ptr_q - 1'b1;
					if (rd_pend_q && ptr_q == pos_q + 1'b1) shift_done_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
					if (rd_pend_q && ptr_q + 1'b1 >= count_q) shift_done_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (op_q == OP_INSERT) count_q <= count_q + 1'b1;
				else count_q <= count_q - 1'b1;
			end
			// mode scan
			if (cmd.mode_start) begin
				ptr_q <= '0;
				mode_done_q <= (count_q == 0);
				rd_pend_q <= 1'b0;
			end
			if (cmd.mode_step && !mode_done_q) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q + 1'b1 >= count_q) mode_done_q <= 1'b1;
			end
			if (cmd.mode_step) begin
				rd_pend_q <= !mode_done_q;
			end
			if (cmd.finish || cmd.mode_start) begin
				pick_idx_q <= '0;
				pick_done_q <= 1'b0;
			end
			if (cmd.pick_step) begin
				pick_idx_q <= pick_idx_q + 1'b1;
				if (pick_idx_q == 3'd5) pick_done_q <= 1'b1;
			end
		end
	end

	// Mode run tracking and pick capture; payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.load) sample_q <= in_sample;
		if (cmd.mode_start) begin
			run_len_q <= '0;
			best_len_q <= '0;
			n_q <= count_q;
			h_q <= count_q >> 1;
		end
		// rdata holds entry ptr on every scan cycle before the scan ends
		if (cmd.mode_step && !mode_done_q) begin
			if (run_len_q != 0 && rval == run_val_q) begin
				run_len_q <= run_len_q + 1'b1;
				if (run_len_q + 1'b1 > best_len_q) begin
					best_len_q <= run_len_q + 1'b1;
					best_val_q <= run_val_q;
				end
			end else begin
				run_val_q <= rval;
				run_len_q <= CountWidth'(1);
				if (best_len_q == 0) begin
					best_len_q <= CountWidth'(1);
					best_val_q <= rval;
				end
			end
		end
		if (cmd.pick_step && pick_idx_q != 0) begin
			pick_val_q[pick_idx_q - 1'b1] <= rval;
		end
		if (cmd.finish) begin
			pick_val_q[5] <= rval;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		logic signed [WideWidth-1:0] med, q1, q3;
		med = WideWidth'(pick_val_q[0]) + WideWidth'(pick_val_q[1]);
		q1 = WideWidth'(pick_val_q[2]) + WideWidth'(pick_val_q[3]);
		q3 = WideWidth'(pick_val_q[4]) + rval;
		if (cmd.finish) begin
			status <= status_q;
			entry_total <= count_q;
			stats_valid <= (count_q != 0);
			if (count_q == 0) begin
				median_x2 <= '0;
				q1_x2 <= '0;
				q3_x2 <= '0;
				iqr_x2 <= '0;
				mode_value <= '0;
			end else begin
				median_x2 <= med;
				q1_x2 <= q1;
				q3_x2 <= q3;
				iqr_x2 <= WideWidth'(q3 - q1);
				mode_value <= best_val_q;
			end
		end
	end

	assign stat.is_remove = (op_q == OP_REMOVE);
	assign stat.full = (count_q >= CountWidth'(Depth));
	assign stat.search_done = search_done_q;
	assign stat.found = found_q;
	assign stat.shift_done = shift_done_q;
	assign stat.mode_done = mode_done_q;
	assign stat.pick_done = pick_done_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mode_step && !mode_done_q && run_len_q != 0) |-> rval >= run_val_q)
		else $error("store out of order");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountWidth'(Depth)) else $error("count overflow");
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> $past(count_q) != count_q) else $error("commit without change");
endmodule

>>> src/wos_ctrl.sv
module wos_ctrl import wos_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  wos_stat_t stat,
	output wos_cmd_t  cmd
);
	wos_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// first cycle only reaches here after load
				if (!stat.is_remove && stat.full) begin
					state_d = S_MODE;
					cmd.mode_start = 1'b1;
				end else begin
					cmd.search_start = 1'b1;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!stat.search_done) begin
					cmd.search_step = 1'b1;
				end else begin
					cmd.search_step = 1'b1;
					if (stat.is_remove && !stat.found) begin
						cmd.search_step = 1'b0;
						cmd.mode_start = 1'b1;
						state_d = S_MODE;
					end else begin
						state_d = S_WRITE;
					end
				end
			end
			S_WRITE: begin
				if (!stat.shift_done) begin
					cmd.shift_step = 1'b1;
				end else begin
					if (!stat.is_remove) cmd.write_new = 1'b1;
					cmd.commit = 1'b1;
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.mode_start = 1'b1;
				state_d = S_MODE;
			end
			S_MODE: begin
				cmd.mode_step = 1'b1;
				if (stat.mode_done) state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.pick_step = 1'b1;
				if (stat.pick_done) begin
					cmd.pick_step = 1'b0;
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.commit, cmd.finish})) else $error("command clash");
	a_outhold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("result not presented");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
endmodule

>>> src/windowed_order_statistics_unit.sv
// Throughput: one item at a time; the search, the shift and the mode scan each
// walk the store through the single read port of the sample RAM, one entry a cycle.
// Reset (arst_n low) empties the store; sample RAM contents need no clearing.
module windowed_order_statistics_unit import wos_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	wos_in_if.sink  in_ch,
	wos_out_if.source out_ch
);
	wos_cmd_t cmd;
	wos_stat_t stat;

	wos_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	wos_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_operation(in_ch.operation), .in_sample(in_ch.sample),
		.status(out_ch.status), .entry_total(out_ch.entry_total),
		.stats_valid(out_ch.stats_valid), .median_x2(out_ch.median_x2),
		.q1_x2(out_ch.q1_x2), .q3_x2(out_ch.q3_x2), .iqr_x2(out_ch.iqr_x2),
		.mode_value(out_ch.mode_value)
	);
endmodule
